/* rtl/brdo_pkg.sv */
// ---------------------------------------------------------------------------
// brdo_pkg: shared definitions for the drop-oldest ring queue
// Operation codes, controller states and the command and status bundles
// passed between the controller and the datapath.
// ---------------------------------------------------------------------------
package brdo_pkg;

  // operation codes on the op field
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_TAKE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // reset value of the queue limit register
  localparam logic [4:0] LIMIT_RESET = 5'd16;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_OUT,
    ST_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input transfer this cycle: latch op and plan
    logic issue_rd;  // read ring head, advance head, drop one from held
    logic load_pop;  // load output register with the popped entry
    logic load_null; // load output register with the single plain result
    logic idle;      // no item in flight
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic plan_none; // incoming item pops nothing
    logic pops_one;  // one pop left for the current item
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

/* rtl/bounded_ring_drop_oldest.sv */
// ---------------------------------------------------------------------------
// bounded_ring_drop_oldest: ring queue of handles that drops the oldest
// Push, take and clear on a limited ring, with 64-bit drop and publish
// counters and one result transfer per popped entry, or one plain result.
// ---------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | op, entry_handle
//  out     | out_valid / out_stall | taken_*, freed_*, entry_count,
//          |                       | dropped_total, published_total, last
//  cfg     | cfg_valid / cfg_ready | cfg_data (queue_limit)
//
//  An item with no pop goes through accept, then load of the result.
//  Each popped entry (eviction, take, cleared entry) costs a registered
//  read of the ring memory at the head, then the result load.
//  out_stall holds the controller in its result-load state; the next item
//  is accepted while the final result still sits in the output register.
//  rst is synchronous; no clearing pass, the ring is read only where written.
// ---------------------------------------------------------------------------
module bounded_ring_drop_oldest #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] entry_handle,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        taken_valid,
  output logic [31:0] taken_handle,
  output logic        freed_valid,
  output logic [31:0] freed_handle,
  output logic [4:0]  entry_count,
  output logic [63:0] dropped_total,
  output logic [63:0] published_total,
  output logic        last
);

  brdo_pkg::ctl_cmd_t cmd;
  brdo_pkg::dp_stat_t stat;

  // input and configuration are taken only between items
  assign in_stall  = !cmd.idle;
  assign cfg_ready = cmd.idle;

  brdo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  brdo_dp #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .op              (op),
    .entry_handle    (entry_handle),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .taken_valid     (taken_valid),
    .taken_handle    (taken_handle),
    .freed_valid     (freed_valid),
    .freed_handle    (freed_handle),
    .entry_count     (entry_count),
    .dropped_total   (dropped_total),
    .published_total (published_total),
    .last            (last)
  );

endmodule

/* rtl/brdo_ctrl.sv */
// ---------------------------------------------------------------------------
// brdo_ctrl: sequencer for the drop-oldest ring queue
// Walks each item through its pops (one head read and one result each) or
// a single plain result, and gates the input and configuration channels.
// ---------------------------------------------------------------------------
module brdo_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  brdo_pkg::dp_stat_t  stat,
  output brdo_pkg::ctl_cmd_t  cmd
);

  brdo_pkg::state_t state;
  brdo_pkg::state_t state_next;
  logic             in_xfer;

  assign in_xfer = in_valid && (state == brdo_pkg::ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brdo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      brdo_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_next = stat.plan_none ? brdo_pkg::ST_FINISH : brdo_pkg::ST_POP_RD;
        end
      end
      brdo_pkg::ST_POP_RD: begin
        state_next = brdo_pkg::ST_POP_OUT;
      end
      brdo_pkg::ST_POP_OUT: begin
        if (stat.out_free) begin
          state_next = stat.pops_one ? brdo_pkg::ST_IDLE : brdo_pkg::ST_POP_RD;
        end
      end
      brdo_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          state_next = brdo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = brdo_pkg::ST_IDLE;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd           = '0;
    cmd.idle      = (state == brdo_pkg::ST_IDLE);
    cmd.accept    = in_xfer;
    cmd.issue_rd  = (state == brdo_pkg::ST_POP_RD);
    cmd.load_pop  = (state == brdo_pkg::ST_POP_OUT) && stat.out_free;
    cmd.load_null = (state == brdo_pkg::ST_FINISH) && stat.out_free;
  end

endmodule

/* rtl/brdo_dp.sv */
// ---------------------------------------------------------------------------
// brdo_dp: datapath for the drop-oldest ring queue
// Ring memory, head and held count, drop and publish counters, limit
// register and the output register.
// ---------------------------------------------------------------------------
module brdo_dp #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  brdo_pkg::ctl_cmd_t  cmd,
  output brdo_pkg::dp_stat_t  stat,
  input  logic [1:0]          op,
  input  logic [31:0]         entry_handle,
  input  logic                cfg_valid,
  input  logic [4:0]          cfg_data,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                taken_valid,
  output logic [31:0]         taken_handle,
  output logic                freed_valid,
  output logic [31:0]         freed_handle,
  output logic [4:0]          entry_count,
  output logic [63:0]         dropped_total,
  output logic [63:0]         published_total,
  output logic                last
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LW    = (CNT_W > 5) ? CNT_W : 5;
  localparam int KEEP  = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

  logic [HANDLE_BITS-1:0] mem [DEPTH];
  logic [HANDLE_BITS-1:0] rd_data;
  logic [HANDLE_BITS-1:0] wr_handle;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [IDX_W-1:0]       head;
  logic [IDX_W-1:0]       head_inc;
  logic [IDX_W-1:0]       tail;
  logic [IDX_W:0]         tail_sum;
  logic [CNT_W-1:0]       held;
  logic [CNT_W-1:0]       fin_count;
  logic [CNT_W-1:0]       pops_left;
  logic [63:0]            drop_cnt;
  logic [63:0]            pub_cnt;
  logic [4:0]             limit_q;
  logic [1:0]             op_q;
  logic                   refuse_q;

  logic [LW-1:0]          lim;
  logic [LW-1:0]          held_w;
  logic [CNT_W-1:0]       plan_pops;
  logic [CNT_W-1:0]       plan_fin;
  logic [CNT_W-1:0]       plan_drop;
  logic                   plan_pub;
  logic                   plan_refuse;
  logic                   last_pop;
  logic                   mem_we;

  // handle kept to HANDLE_BITS, outputs cut to 32
  assign wr_handle = HANDLE_BITS'(entry_handle[KEEP-1:0]);

  // effective limit is min(queue_limit, DEPTH)
  assign lim    = (LW'(limit_q) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(limit_q);
  assign held_w = LW'(held);

  // ring arithmetic, modulo DEPTH
  assign head_inc = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum = {1'b0, head} + (IDX_W + 1)'(held);
  assign tail     = (tail_sum >= (IDX_W + 1)'(DEPTH)) ?
                    IDX_W'(tail_sum - (IDX_W + 1)'(DEPTH)) : IDX_W'(tail_sum);

  // plan for the incoming item: pops, final held count, counter steps
  always_comb begin
    plan_pops   = '0;
    plan_fin    = held;
    plan_drop   = '0;
    plan_pub    = 1'b0;
    plan_refuse = 1'b0;
    unique case (op)
      brdo_pkg::OP_PUSH: begin
        if (lim == '0) begin
          plan_drop   = CNT_W'(1);
          plan_refuse = 1'b1;
        end else if (held_w >= lim) begin
          plan_pops = CNT_W'(held_w - lim + LW'(1));
          plan_fin  = CNT_W'(lim);
          plan_drop = CNT_W'(held_w - lim + LW'(1));
          plan_pub  = 1'b1;
        end else begin
          plan_fin = held + 1'b1;
          plan_pub = 1'b1;
        end
      end
      brdo_pkg::OP_TAKE: begin
        if (held != '0) begin
          plan_pops = CNT_W'(1);
          plan_fin  = held - 1'b1;
        end
      end
      brdo_pkg::OP_CLEAR: begin
        plan_pops = held;
        plan_fin  = '0;
      end
      default: begin
        plan_pops = '0;
      end
    endcase
  end

  assign last_pop = (pops_left == CNT_W'(1));

  // status to controller
  always_comb begin
    stat           = '0;
    stat.plan_none = (plan_pops == '0);
    stat.pops_one  = last_pop;
    stat.out_free  = !out_valid || !out_stall;
  end

  // the pushed handle goes in once evictions are done
  assign mem_we = (op_q == brdo_pkg::OP_PUSH) &&
                  ((cmd.load_pop && last_pop) || (cmd.load_null && !refuse_q));

  // ring memory: one write at the tail, one registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= handle_q;
    end
    if (cmd.issue_rd) begin
      rd_data <= mem[head];
    end
  end

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_q <= brdo_pkg::LIMIT_RESET;
    end else if (cfg_valid && cmd.idle) begin
      limit_q <= cfg_data;
    end
  end

  // item latch and plan, payload only
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q      <= op;
      handle_q  <= wr_handle;
      fin_count <= plan_fin;
      refuse_q  <= plan_refuse;
    end
  end

  // ring control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      held      <= '0;
      pops_left <= '0;
      drop_cnt  <= '0;
      pub_cnt   <= '0;
    end else begin
      if (cmd.accept) begin
        pops_left <= plan_pops;
        drop_cnt  <= drop_cnt + 64'(plan_drop);
        pub_cnt   <= pub_cnt + 64'(plan_pub);
      end
      if (cmd.issue_rd) begin
        head <= head_inc;
        held <= held - 1'b1;
      end
      if (cmd.load_pop) begin
        pops_left <= pops_left - 1'b1;
        if (last_pop) begin
          if (op_q == brdo_pkg::OP_PUSH) begin
            held <= held + 1'b1;
          end else if (held == '0) begin
            head <= '0;
          end
        end
      end
      if (cmd.load_null) begin
        if (op_q == brdo_pkg::OP_PUSH && !refuse_q) begin
          held <= held + 1'b1;
        end
        if (op_q == brdo_pkg::OP_CLEAR) begin
          head <= '0;
        end
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_pop || cmd.load_null) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.load_pop) begin
      taken_valid     <= (op_q == brdo_pkg::OP_TAKE);
      taken_handle    <= (op_q == brdo_pkg::OP_TAKE) ? 32'(rd_data[KEEP-1:0]) : '0;
      freed_valid     <= (op_q != brdo_pkg::OP_TAKE);
      freed_handle    <= (op_q != brdo_pkg::OP_TAKE) ? 32'(rd_data[KEEP-1:0]) : '0;
      entry_count     <= 5'(fin_count);
      dropped_total   <= drop_cnt;
      published_total <= pub_cnt;
      last            <= last_pop;
    end else if (cmd.load_null) begin
      taken_valid     <= 1'b0;
      taken_handle    <= '0;
      freed_valid     <= refuse_q;
      freed_handle    <= refuse_q ? 32'(handle_q[KEEP-1:0]) : '0;
      entry_count     <= 5'(fin_count);
      dropped_total   <= drop_cnt;
      published_total <= pub_cnt;
      last            <= 1'b1;
    end
  end

endmodule

/* rtl/brdo_check.sv */
// ---------------------------------------------------------------------------
// brdo_check: port-level checks for the drop-oldest ring queue
// Watches the result channel over time; attached to the top level by bind.
// ---------------------------------------------------------------------------
module brdo_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        taken_valid,
  input logic [31:0] taken_handle,
  input logic        freed_valid,
  input logic [31:0] freed_handle,
  input logic [4:0]  entry_count,
  input logic [63:0] dropped_total,
  input logic [63:0] published_total,
  input logic        last
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(taken_handle) &&
      $stable(freed_handle) && $stable(dropped_total) && $stable(last))
    else $error("result changed while stalled");

  // a result never both takes and frees
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(taken_valid && freed_valid))
    else $error("result both taken and freed");

  // a take result is always marked last
  a_take_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && taken_valid |-> last)
    else $error("take result not marked last");

  // handles read zero when their valid bit is low
  a_zero_handles: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (taken_valid || taken_handle == '0) &&
                  (freed_valid || freed_handle == '0))
    else $error("handle set without its valid bit");

endmodule

bind bounded_ring_drop_oldest brdo_check u_brdo_check (.*);
